// File: hdl/scp_pkg.sv
// Shared types, character codes and command word table for the command line parser.
package scp_pkg;

    localparam int NAME_LIMIT_DEF  = 10;
    localparam int VALUE_LIMIT_DEF = 10;

    // Width of a field length; it can express lengths up to 31 characters.
    localparam int LEN_W = 5;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [1:0] MODE_NAME   = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_SECOND = 2'd2;

    localparam int NUM_WORDS = 6;

    // One completed command waiting for the back end.
    typedef struct packed {
        logic [LEN_W-1:0] name_len;
        logic [LEN_W-1:0] first_len;
        logic [LEN_W-1:0] second_len;
        logic             too_long;
    } job_t;

    // Command words, first character in the top byte.
    function automatic logic [55:0] word_text(input logic [2:0] w);
        logic [55:0] t;
        unique case (w)
            3'd0:    t = {"H", 48'h0};
            3'd1:    t = {"HELP", 24'h0};
            3'd2:    t = {"R", 48'h0};
            3'd3:    t = {"RATE", 24'h0};
            3'd4:    t = {"X", 48'h0};
            default: t = "STOPALL";
        endcase
        return t;
    endfunction

    function automatic logic [2:0] word_len(input logic [2:0] w);
        logic [2:0] l;
        unique case (w)
            3'd0, 3'd2, 3'd4: l = 3'd1;
            3'd1, 3'd3:       l = 3'd4;
            default:          l = 3'd7;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] i);
        logic [55:0] s;
        s = word_text(w) << {i, 3'b000};
        return s[55:48];
    endfunction

    function automatic logic [1:0] word_code(input logic [2:0] w);
        return w[2:1] + 2'd1;
    endfunction

endpackage

// File: hdl/scp_front.sv
// Front end: takes characters, fills the three field stores and queues completed commands.
module scp_front
    import scp_pkg::*;
#(
    parameter int NAME_LIMIT  = NAME_LIMIT_DEF,
    parameter int VALUE_LIMIT = VALUE_LIMIT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    output job_t                        job,
    output logic                        job_valid,
    input  logic                        job_take,
    output logic [NAME_LIMIT:0][7:0]    name_buf,
    output logic [VALUE_LIMIT:0][7:0]   first_buf,
    output logic [VALUE_LIMIT:0][7:0]   second_buf
);

    localparam int NW = $clog2(NAME_LIMIT + 1);
    localparam int VW = $clog2(VALUE_LIMIT + 1);

    logic [1:0]    mode_reg, mode_next;
    logic [NW-1:0] name_count_reg, name_count_next;
    logic [VW-1:0] first_count_reg, first_count_next;
    logic [VW-1:0] second_count_reg, second_count_next;
    logic          job_valid_reg, job_valid_next;
    job_t          job_reg, job_next;

    logic [NAME_LIMIT:0][7:0]  name_buf_reg;
    logic [VALUE_LIMIT:0][7:0] first_buf_reg;
    logic [VALUE_LIMIT:0][7:0] second_buf_reg;

    logic       accept;
    logic       wr_name, wr_first, wr_second;
    logic [7:0] upper;

    assign accept = s_tvalid && s_tready;
    assign upper  = (s_tdata >= "a" && s_tdata <= "z") ? s_tdata - 8'd32 : s_tdata;

    always_comb
    begin
        mode_next         = mode_reg;
        name_count_next   = name_count_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        job_next          = job_reg;
        job_valid_next    = job_valid_reg && !job_take;
        wr_name           = 1'b0;
        wr_first          = 1'b0;
        wr_second         = 1'b0;
        if (accept)
        begin
            priority if (s_tdata == CH_LF || s_tdata == CH_SPACE ||
                         s_tdata == CH_TAB || s_tdata == CH_CR)
            begin
                mode_next = mode_reg;
            end
            else if (s_tdata == CH_SEMI)
            begin
                job_next = '{name_len: LEN_W'(name_count_reg),
                             first_len: LEN_W'(first_count_reg),
                             second_len: LEN_W'(second_count_reg),
                             too_long: 1'b0};
                job_valid_next    = 1'b1;
                name_count_next   = '0;
                first_count_next  = '0;
                second_count_next = '0;
                mode_next         = MODE_NAME;
            end
            else if (s_tdata == CH_COMMA && mode_reg == MODE_NAME)
            begin
                mode_next = MODE_FIRST;
            end
            else if (s_tdata == CH_COMMA && mode_reg == MODE_FIRST)
            begin
                mode_next = MODE_SECOND;
            end
            else if (mode_reg == MODE_NAME)
            begin
                wr_name = 1'b1;
                if (name_count_reg == NW'(NAME_LIMIT))
                begin
                    job_next = '{name_len: LEN_W'(NAME_LIMIT + 1),
                                 first_len: LEN_W'(first_count_reg),
                                 second_len: LEN_W'(second_count_reg),
                                 too_long: 1'b1};
                    job_valid_next  = 1'b1;
                    name_count_next = '0;
                end
                else
                begin
                    name_count_next = name_count_reg + 1'b1;
                end
            end
            else if (mode_reg == MODE_FIRST)
            begin
                wr_first = 1'b1;
                if (first_count_reg == VW'(VALUE_LIMIT))
                begin
                    job_next = '{name_len: LEN_W'(name_count_reg),
                                 first_len: LEN_W'(VALUE_LIMIT + 1),
                                 second_len: LEN_W'(second_count_reg),
                                 too_long: 1'b1};
                    job_valid_next   = 1'b1;
                    first_count_next = '0;
                end
                else
                begin
                    first_count_next = first_count_reg + 1'b1;
                end
            end
            else
            begin
                wr_second = 1'b1;
                if (second_count_reg == VW'(VALUE_LIMIT))
                begin
                    job_next = '{name_len: LEN_W'(name_count_reg),
                                 first_len: LEN_W'(first_count_reg),
                                 second_len: LEN_W'(VALUE_LIMIT + 1),
                                 too_long: 1'b1};
                    job_valid_next    = 1'b1;
                    second_count_next = '0;
                end
                else
                begin
                    second_count_next = second_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NAME;
            name_count_reg   <= '0;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            job_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            name_count_reg   <= name_count_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            job_valid_reg    <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (wr_name)
        begin
            name_buf_reg[name_count_reg] <= upper;
        end
        if (wr_first)
        begin
            first_buf_reg[first_count_reg] <= s_tdata;
        end
        if (wr_second)
        begin
            second_buf_reg[second_count_reg] <= s_tdata;
        end
    end

    // The stores are held still while a command waits, so the back end copies a whole command.
    assign s_tready   = !job_valid_reg;
    assign job        = job_reg;
    assign job_valid  = job_valid_reg;
    assign name_buf   = name_buf_reg;
    assign first_buf  = first_buf_reg;
    assign second_buf = second_buf_reg;

    a_name_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        name_count_reg <= NW'(NAME_LIMIT))
        else $error("name count beyond its limit");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_take |=> job_valid_reg && $stable(job_reg))
        else $error("queued command lost or changed before it was taken");

endmodule

// File: hdl/scp_back.sv
// Back end: matches the command name and converts both value fields one character a cycle.
module scp_back
    import scp_pkg::*;
#(
    parameter int NAME_LIMIT  = NAME_LIMIT_DEF,
    parameter int VALUE_LIMIT = VALUE_LIMIT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  job_t                        job,
    input  logic                        job_valid,
    output logic                        job_take,
    input  logic [NAME_LIMIT:0][7:0]    name_buf,
    input  logic [VALUE_LIMIT:0][7:0]   first_buf,
    input  logic [VALUE_LIMIT:0][7:0]   second_buf,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,
    output logic                        m_tuser
);

    localparam int NW = $clog2(NAME_LIMIT + 1);
    localparam int VW = $clog2(VALUE_LIMIT + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NAME = 4'd1;
    localparam logic [3:0] ST_SKIP = 4'd2;
    localparam logic [3:0] ST_SIGN = 4'd3;
    localparam logic [3:0] ST_PRE0 = 4'd4;
    localparam logic [3:0] ST_PRE1 = 4'd5;
    localparam logic [3:0] ST_PRE2 = 4'd6;
    localparam logic [3:0] ST_DIG  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    localparam logic [1:0] BASE_8  = 2'd0;
    localparam logic [1:0] BASE_10 = 2'd1;
    localparam logic [1:0] BASE_16 = 2'd2;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        priority if (c >= "0" && c <= "9") d = 6'(c - 8'd48);
        else if (c >= "a" && c <= "z")     d = 6'(c - 8'd87);
        else if (c >= "A" && c <= "Z")     d = 6'(c - 8'd55);
        else                               d = 6'd63;
        return d;
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [LEN_W-1:0] rp_reg, rp_next;
    logic [LEN_W-1:0] zpos_reg, zpos_next;
    logic [LEN_W-1:0] nn_reg, nn_next, n1_reg, n1_next, n2_reg, n2_next;
    logic             flag_reg, flag_next;
    logic [NUM_WORDS-1:0] ok_reg, ok_next;
    logic [1:0]       code_reg, code_next;
    logic             fld_reg, fld_next;
    logic             neg_reg, neg_next;
    logic [1:0]       base_reg, base_next;
    logic [31:0]      mag_reg, mag_next;
    logic [31:0]      v1_reg, v1_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [71:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic [NAME_LIMIT:0][7:0]  nb_reg;
    logic [VALUE_LIMIT:0][7:0] fb_reg, sb_reg;

    logic [7:0]       nch, cur;
    logic [LEN_W-1:0] nfield;
    logic             in_field;
    logic [5:0]       dig;
    logic [5:0]       base_lim;
    logic [35:0]      prod;
    logic [31:0]      value;

    assign job_take = (state_reg == ST_IDLE) && job_valid;
    assign nch      = nb_reg[rp_reg[NW-1:0]];
    assign cur      = fld_reg ? sb_reg[rp_reg[VW-1:0]] : fb_reg[rp_reg[VW-1:0]];
    assign nfield   = fld_reg ? n2_reg : n1_reg;
    assign in_field = rp_reg < nfield;
    assign dig      = digit_of(cur);

    always_comb
    begin
        unique case (base_reg)
            BASE_8:  base_lim = 6'd8;
            BASE_16: base_lim = 6'd16;
            default: base_lim = 6'd10;
        endcase
        unique case (base_reg)
            BASE_8:  prod = {1'b0, mag_reg, 3'b000};
            BASE_16: prod = {mag_reg, 4'b0000};
            default: prod = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0};
        endcase
        prod = prod + 36'(dig);
        if (neg_reg)
        begin
            value = (mag_reg >= MAG_CAP) ? MAG_CAP : (~mag_reg + 32'd1);
        end
        else
        begin
            value = (mag_reg > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rp_next       = rp_reg;
        zpos_next     = zpos_reg;
        nn_next       = nn_reg;
        n1_next       = n1_reg;
        n2_next       = n2_reg;
        flag_next     = flag_reg;
        ok_next       = ok_reg;
        code_next     = code_reg;
        fld_next      = fld_reg;
        neg_next      = neg_reg;
        base_next     = base_reg;
        mag_next      = mag_reg;
        v1_next       = v1_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    nn_next    = job.name_len;
                    n1_next    = job.first_len;
                    n2_next    = job.second_len;
                    flag_next  = job.too_long;
                    rp_next    = '0;
                    ok_next    = '1;
                    state_next = ST_NAME;
                end
            end
            ST_NAME:
            begin
                if (rp_reg < nn_reg && nch != 8'h00)
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                    begin
                        ok_next[k] = ok_reg[k] && (rp_reg < LEN_W'(word_len(3'(k)))) &&
                                     (nch == word_char(3'(k), rp_reg[2:0]));
                    end
                    rp_next = rp_reg + 1'b1;
                end
                else
                begin
                    code_next = 2'd0;
                    for (int k = NUM_WORDS - 1; k >= 0; k--)
                    begin
                        if (ok_reg[k] && rp_reg == LEN_W'(word_len(3'(k))))
                        begin
                            code_next = word_code(3'(k));
                        end
                    end
                    fld_next   = 1'b0;
                    rp_next    = '0;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (in_field && (cur == CH_SPACE || (cur >= 8'd9 && cur <= 8'd13)))
                begin
                    rp_next = rp_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (in_field && (cur == "+" || cur == "-"))
                begin
                    neg_next = (cur == "-");
                    rp_next  = rp_reg + 1'b1;
                end
                state_next = ST_PRE0;
            end
            ST_PRE0:
            begin
                base_next = BASE_10;
                if (in_field && cur == "0")
                begin
                    zpos_next  = rp_reg;
                    rp_next    = rp_reg + 1'b1;
                    state_next = ST_PRE1;
                end
                else
                begin
                    state_next = ST_DIG;
                end
            end
            ST_PRE1:
            begin
                if (({1'b0, zpos_reg} + 6'd2 < {1'b0, nfield}) && (cur == "x" || cur == "X"))
                begin
                    rp_next    = rp_reg + 1'b1;
                    state_next = ST_PRE2;
                end
                else
                begin
                    base_next  = BASE_8;
                    rp_next    = zpos_reg;
                    state_next = ST_DIG;
                end
            end
            ST_PRE2:
            begin
                if (dig < 6'd16)
                begin
                    base_next = BASE_16;
                end
                else
                begin
                    base_next = BASE_8;
                    rp_next   = zpos_reg;
                end
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                if (in_field && dig < base_lim)
                begin
                    mag_next = (prod > 36'(MAG_CAP)) ? MAG_CAP : prod[31:0];
                    rp_next  = rp_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!fld_reg)
                begin
                    v1_next    = value;
                    fld_next   = 1'b1;
                    rp_next    = '0;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                    state_next = ST_SKIP;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {6'b000000, value, v1_reg, code_reg};
                    m_tuser_next  = flag_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // The second value stays in the accumulator until ST_OUT finds the output register free.
    always_ff @(posedge clk)
    begin
        rp_reg      <= rp_next;
        zpos_reg    <= zpos_next;
        nn_reg      <= nn_next;
        n1_reg      <= n1_next;
        n2_reg      <= n2_next;
        flag_reg    <= flag_next;
        ok_reg      <= ok_next;
        code_reg    <= code_next;
        fld_reg     <= fld_next;
        neg_reg     <= neg_next;
        base_reg    <= base_next;
        mag_reg     <= mag_next;
        v1_reg      <= v1_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
        if (job_take)
        begin
            nb_reg <= name_buf;
            fb_reg <= first_buf;
            sb_reg <= second_buf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_mag_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIG || state_reg == ST_FIN) |-> mag_reg <= MAG_CAP)
        else $error("magnitude accumulator passed its saturation cap");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result published outside the output step");

endmodule

// File: hdl/serial_command_line_parser_core.sv
// Top level of the serial command line parser: front end, command queue and back end.
//
// Usage: characters arrive one per transaction on the slave stream (s_tdata[7:0]).
// Newline, carriage return, space and tab are dropped. A comma advances from the
// name field to the first value and then to the second value. A semicolon, or a
// field that grows past its limit, completes a command and produces one result
// transaction on the master stream.
// Flow: after a completing character s_tready drops until the back end takes the
// command, as soon as it is queued when the back end is idle, otherwise once it
// has finished the previous command. The back end walks the stored characters
// one per cycle.
// Reset clears the field mode, the counts and both handshakes; the character
// stores hold whatever they held until written. If the receiver stalls, the
// result is held in the output register while the back end converts the next
// command, which then waits in the back end until the output register is free,
// with s_tready low once a further command has been queued.
module serial_command_line_parser_core
    import scp_pkg::*;
#(
    parameter int NAME_LIMIT  = NAME_LIMIT_DEF,
    parameter int VALUE_LIMIT = VALUE_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [1:0] command_code, [33:2] first_value,
                                   // [65:34] second_value, [71:66] zero
    output logic        m_tuser    // [0] too_long
);

    job_t                      job;
    logic                      job_valid;
    logic                      job_take;
    logic [NAME_LIMIT:0][7:0]  name_buf;
    logic [VALUE_LIMIT:0][7:0] first_buf;
    logic [VALUE_LIMIT:0][7:0] second_buf;

    // The front end classifies and stores characters; its single queued command
    // lets it keep taking input while the back end is still converting.
    scp_front #(
        .NAME_LIMIT  (NAME_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .job        (job),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .name_buf   (name_buf),
        .first_buf  (first_buf),
        .second_buf (second_buf)
    );

    // The back end copies the stores when it takes a command, then matches the
    // name and converts the values into its output register.
    scp_back #(
        .NAME_LIMIT  (NAME_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .name_buf   (name_buf),
        .first_buf  (first_buf),
        .second_buf (second_buf),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
